/* src/json_token_scanner_top_macros.svh */
// Assertion macros for the JSON token scanner.
`ifndef JSON_TOKEN_SCANNER_TOP_MACROS_SVH
`define JSON_TOKEN_SCANNER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JTS_ASSERT_SAME(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error("json scanner check failed");
`define JTS_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("json scanner check failed");
`else
`define JTS_ASSERT_SAME(lbl, ante, cons)
`define JTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/jts_pkg.sv */
// Shared types, codes and keyword tables of the JSON token scanner.
package jts_pkg;

	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_KW_TRUE  = 3'd1;
	localparam logic [2:0] MODE_KW_FALSE = 3'd2;
	localparam logic [2:0] MODE_KW_NULL  = 3'd3;
	localparam logic [2:0] MODE_STRING   = 3'd4;
	localparam logic [2:0] MODE_NUMBER   = 3'd5;

	localparam logic [2:0] NP_SIGN   = 3'd0;
	localparam logic [2:0] NP_INT    = 3'd1;
	localparam logic [2:0] NP_FRAC   = 3'd2;
	localparam logic [2:0] NP_EXP    = 3'd3;
	localparam logic [2:0] NP_EXPDIG = 3'd4;

	localparam logic [3:0] KIND_NONE   = 4'd0;
	localparam logic [3:0] KIND_LBRACE = 4'd1;
	localparam logic [3:0] KIND_RBRACE = 4'd2;
	localparam logic [3:0] KIND_LBRACK = 4'd3;
	localparam logic [3:0] KIND_RBRACK = 4'd4;
	localparam logic [3:0] KIND_COMMA  = 4'd5;
	localparam logic [3:0] KIND_COLON  = 4'd6;
	localparam logic [3:0] KIND_TRUE   = 4'd7;
	localparam logic [3:0] KIND_STRING = 4'd10;
	localparam logic [3:0] KIND_INT    = 4'd11;
	localparam logic [3:0] KIND_FLOAT  = 4'd12;
	localparam logic [3:0] KIND_ERROR  = 4'd13;
	localparam logic [3:0] KIND_END    = 4'd14;

	localparam logic [15:0] TLEN_MAX = 16'hFFFF;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  phase;
		logic [2:0]  kwpos;
		logic [1:0]  utf8;
		logic        esc;
		logic        err;
		logic [15:0] tlen;
	} jts_state_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] lexeme;
		logic       bvalid;
		logic       tend;
	} jts_res_t;

	localparam jts_state_t STATE_RESET = '{
		mode: MODE_IDLE, phase: NP_SIGN, kwpos: 3'd0, utf8: 2'd0,
		esc: 1'b0, err: 1'b0, tlen: 16'd0};

	function automatic jts_state_t clear_token(input jts_state_t s);
		jts_state_t r;
		r = STATE_RESET;
		r.err = s.err;
		return r;
	endfunction

	function automatic jts_res_t mk_res(input logic [3:0] kind, input logic [7:0] lexeme,
		input logic bvalid, input logic tend);
		jts_res_t r;
		r.kind = kind;
		r.lexeme = lexeme;
		r.bvalid = bvalid;
		r.tend = tend;
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] w);
		logic [2:0] l;
		unique case (w)
			2'd1:    l = 3'd5;
			default: l = 3'd4;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
		logic [39:0] txt;
		logic [7:0]  c;
		unique case (w)
			2'd0:    txt = {"true", 8'h00};
			2'd1:    txt = "false";
			default: txt = {"null", 8'h00};
		endcase
		unique case (p)
			3'd0:    c = txt[39:32];
			3'd1:    c = txt[31:24];
			3'd2:    c = txt[23:16];
			3'd3:    c = txt[15:8];
			default: c = txt[7:0];
		endcase
		return c;
	endfunction

endpackage

/* src/json_token_scanner_top.sv */
// JSON token scanner: one text byte per input beat, token results out.
//
// Input channel: in_valid/in_ready carry in_byte and end_of_input. One byte
// is taken per cycle while in_ready is high. A beat with end_of_input set
// closes any open token, gives the end result and returns the scanner to its
// reset state. Output channel: out_valid/out_ready carry one result per beat:
// token_kind, lexeme_byte with byte_valid, token_end and the line and column
// position. A byte gives zero, one or two results. They are decided in the
// cycle the byte is taken and land in a four-entry result queue; the first
// can leave on the next cycle. Throughput is one byte per cycle as long as
// the receiver drains the queue and bytes give at most one result. in_ready
// is high while the queue has room for two results, so a stalled receiver
// fills the queue and then holds off the sender without losing anything.
// Reset clears the scanner state, sets line and column to 1 and empties
// the queue.
`include "json_token_scanner_top_macros.svh"

module json_token_scanner_top #(
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	input  logic                     end_of_input,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [3:0]               token_kind,
	output logic [7:0]               lexeme_byte,
	output logic                     byte_valid,
	output logic                     token_end,
	output logic [POSITION_BITS-1:0] line_number,
	output logic [POSITION_BITS-1:0] column_number
);

	jts_pkg::jts_state_t       st_q, st_next;
	logic [POSITION_BITS-1:0]  line_q, line_next;
	logic [POSITION_BITS-1:0]  col_q, col_next;
	logic [1:0]                n_res;
	jts_pkg::jts_res_t         res0, res1;
	logic [POSITION_BITS-1:0]  col0, col1;

	jts_pkg::jts_res_t         fifo_res_q  [jts_pkg::FIFO_DEPTH];
	logic [POSITION_BITS-1:0]  fifo_col_q  [jts_pkg::FIFO_DEPTH];
	logic [POSITION_BITS-1:0]  fifo_line_q [jts_pkg::FIFO_DEPTH];
	logic [jts_pkg::FIFO_AW-1:0] head_q, tail_q, tail_p1;
	logic [jts_pkg::FIFO_AW:0]   count_q;
	logic                      in_fire, out_fire;

	jts_step #(.POSITION_BITS(POSITION_BITS)) u_step (
		.st           (st_q),
		.line_cur     (line_q),
		.col_cur      (col_q),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.st_next      (st_next),
		.line_next    (line_next),
		.col_next     (col_next),
		.n_res        (n_res),
		.res0         (res0),
		.res1         (res1),
		.col0         (col0),
		.col1         (col1)
	);

	assign in_ready  = count_q <= (jts_pkg::FIFO_AW+1)'(jts_pkg::FIFO_DEPTH - 2);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = count_q != '0;
	assign out_fire  = out_valid && out_ready;
	assign tail_p1   = tail_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= jts_pkg::STATE_RESET;
			line_q  <= POSITION_BITS'(1);
			col_q   <= POSITION_BITS'(1);
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (in_fire) begin
				st_q   <= st_next;
				line_q <= line_next;
				col_q  <= col_next;
				tail_q <= tail_q + jts_pkg::FIFO_AW'(n_res);
			end
			if (out_fire)
				head_q <= head_q + 1'b1;
			count_q <= count_q + (in_fire ? (jts_pkg::FIFO_AW+1)'(n_res) : '0)
				- (jts_pkg::FIFO_AW+1)'(out_fire);
		end
	end

	// Result payload storage needs no reset.
	always_ff @(posedge clk) begin
		if (in_fire && n_res != 2'd0) begin
			fifo_res_q[tail_q]  <= res0;
			fifo_col_q[tail_q]  <= col0;
			fifo_line_q[tail_q] <= line_q;
		end
		if (in_fire && n_res == 2'd2) begin
			fifo_res_q[tail_p1]  <= res1;
			fifo_col_q[tail_p1]  <= col1;
			fifo_line_q[tail_p1] <= line_q;
		end
	end

	assign token_kind    = fifo_res_q[head_q].kind;
	assign lexeme_byte   = fifo_res_q[head_q].lexeme;
	assign byte_valid    = fifo_res_q[head_q].bvalid;
	assign token_end     = fifo_res_q[head_q].tend;
	assign line_number   = fifo_line_q[head_q];
	assign column_number = fifo_col_q[head_q];

	`JTS_ASSERT_SAME(a_queue_bound, 1'b1, count_q <= (jts_pkg::FIFO_AW+1)'(jts_pkg::FIFO_DEPTH))
	`JTS_ASSERT_SAME(a_error_silent, in_fire && st_q.err && !end_of_input, n_res == 2'd0)
	`JTS_ASSERT_NEXT(a_end_restarts, in_fire && end_of_input, line_q == POSITION_BITS'(1) && col_q == POSITION_BITS'(1) && st_q.mode == jts_pkg::MODE_IDLE && !st_q.err)

endmodule

/* src/jts_step.sv */
// Next-state and result logic of the scanner for one input beat.
module jts_step #(
	parameter int POSITION_BITS = 16
) (
	input  jts_pkg::jts_state_t       st,
	input  logic [POSITION_BITS-1:0]  line_cur,
	input  logic [POSITION_BITS-1:0]  col_cur,
	input  logic [7:0]                in_byte,
	input  logic                      end_of_input,
	output jts_pkg::jts_state_t       st_next,
	output logic [POSITION_BITS-1:0]  line_next,
	output logic [POSITION_BITS-1:0]  col_next,
	output logic [1:0]                n_res,
	output jts_pkg::jts_res_t         res0,
	output jts_pkg::jts_res_t         res1,
	output logic [POSITION_BITS-1:0]  col0,
	output logic [POSITION_BITS-1:0]  col1
);

	localparam int SW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	function automatic logic [POSITION_BITS-1:0] sat_add(input logic [POSITION_BITS-1:0] a,
		input logic [15:0] x);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(x);
		if (s > SW'(POS_MAX))
			return POS_MAX;
		return POSITION_BITS'(s);
	endfunction

	function automatic logic [15:0] grow(input logic [15:0] t);
		return (t < jts_pkg::TLEN_MAX) ? t + 16'd1 : t;
	endfunction

	jts_pkg::jts_state_t       nx;
	logic [POSITION_BITS-1:0]  ln;
	logic [POSITION_BITS-1:0]  cl;
	logic [1:0]                n;
	jts_pkg::jts_res_t         r [2];
	logic [POSITION_BITS-1:0]  c [2];
	logic                      do_idle;
	logic [7:0]                b;
	logic [15:0]               tl;
	logic [1:0]                w;
	logic [3:0]                punct;
	logic                      is_digit;

	always_comb begin
		nx = st;
		ln = line_cur;
		cl = col_cur;
		n = 2'd0;
		r[0] = '0;
		r[1] = '0;
		c[0] = '0;
		c[1] = '0;
		do_idle = 1'b0;
		b = in_byte;
		tl = grow(st.tlen);
		w = 2'(st.mode - jts_pkg::MODE_KW_TRUE);
		is_digit = (b >= "0") && (b <= "9");
		punct = jts_pkg::KIND_NONE;

		if (end_of_input) begin
			if (!st.err) begin
				if (st.mode == jts_pkg::MODE_NUMBER) begin
					if (st.phase == jts_pkg::NP_INT || st.phase == jts_pkg::NP_FRAC ||
						st.phase == jts_pkg::NP_EXPDIG) begin
						cl = sat_add(cl, st.tlen);
						r[n[0]] = jts_pkg::mk_res((st.phase == jts_pkg::NP_INT) ?
							jts_pkg::KIND_INT : jts_pkg::KIND_FLOAT, 8'h00, 1'b0, 1'b1);
					end else begin
						r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
					end
					c[n[0]] = cl;
					n = n + 2'd1;
				end else if (st.mode != jts_pkg::MODE_IDLE) begin
					r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
					c[n[0]] = cl;
					n = n + 2'd1;
				end
			end
			r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_END, 8'h00, 1'b0, 1'b1);
			c[n[0]] = cl;
			n = n + 2'd1;
			nx = jts_pkg::STATE_RESET;
			ln = POS_ONE;
			cl = POS_ONE;
		end else if (!st.err) begin
			case (st.mode)
				jts_pkg::MODE_KW_TRUE, jts_pkg::MODE_KW_FALSE, jts_pkg::MODE_KW_NULL: begin
					if (st.kwpos >= jts_pkg::kw_len(w) || b != jts_pkg::kw_char(w, st.kwpos)) begin
						nx = jts_pkg::clear_token(st);
						nx.err = 1'b1;
						r[0] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
					end else if (st.kwpos + 3'd1 == jts_pkg::kw_len(w)) begin
						cl = sat_add(cl, tl);
						nx = jts_pkg::clear_token(st);
						r[0] = jts_pkg::mk_res(jts_pkg::KIND_TRUE + 4'(w), b, 1'b1, 1'b1);
					end else begin
						nx.kwpos = st.kwpos + 3'd1;
						nx.tlen = tl;
						r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
					end
					c[0] = cl;
					n = 2'd1;
				end
				jts_pkg::MODE_STRING: begin
					if (st.esc) begin
						nx.esc = 1'b0;
						nx.tlen = tl;
						n = 2'd1;
						case (b)
							"n":     r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, 8'h0A, 1'b1, 1'b0);
							"t":     r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, 8'h09, 1'b1, 1'b0);
							"\\":    r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, "\\", 1'b1, 1'b0);
							"\"":    r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, "\"", 1'b1, 1'b0);
							"r":     r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, 8'h0D, 1'b1, 1'b0);
							"b":     r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, 8'h08, 1'b1, 1'b0);
							"f":     r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, 8'h0C, 1'b1, 1'b0);
							default: begin
								// Unknown escape: pass the backslash and the byte itself.
								r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, "\\", 1'b1, 1'b0);
								r[1] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
								n = 2'd2;
							end
						endcase
						c[0] = cl;
						c[1] = cl;
					end else if (st.utf8 != 2'd0) begin
						if ((b & 8'hC0) != 8'h80) begin
							nx = jts_pkg::clear_token(st);
							nx.err = 1'b1;
							r[0] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
						end else begin
							nx.utf8 = st.utf8 - 2'd1;
							nx.tlen = tl;
							r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
						end
						c[0] = cl;
						n = 2'd1;
					end else if (b == "\"") begin
						cl = sat_add(cl, tl);
						nx = jts_pkg::clear_token(st);
						r[0] = jts_pkg::mk_res(jts_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1);
						c[0] = cl;
						n = 2'd1;
					end else if (b == "\\") begin
						nx.esc = 1'b1;
						nx.tlen = tl;
					end else begin
						nx.tlen = tl;
						if (b[7]) begin
							if ((b & 8'hF0) == 8'hF0)
								nx.utf8 = 2'd3;
							else if ((b & 8'hE0) == 8'hE0)
								nx.utf8 = 2'd2;
							else
								nx.utf8 = 2'd1;
						end
						r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
						c[0] = cl;
						n = 2'd1;
					end
				end
				jts_pkg::MODE_NUMBER: begin
					if (is_digit || b == "." || b == "e" || b == "E" || b == "+" || b == "-")
							begin
						if ((b == "." && st.phase > jts_pkg::NP_INT) ||
							((b == "e" || b == "E") &&
								(st.phase > jts_pkg::NP_FRAC || st.phase == jts_pkg::NP_SIGN)) ||
							((b == "+" || b == "-") && st.phase != jts_pkg::NP_EXP)) begin
							nx = jts_pkg::clear_token(st);
							nx.err = 1'b1;
							r[0] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
						end else begin
							if (is_digit) begin
								if (st.phase == jts_pkg::NP_SIGN)
									nx.phase = jts_pkg::NP_INT;
								else if (st.phase == jts_pkg::NP_EXP)
									nx.phase = jts_pkg::NP_EXPDIG;
							end else if (b == ".") begin
								nx.phase = jts_pkg::NP_FRAC;
							end else if (b == "e" || b == "E") begin
								nx.phase = jts_pkg::NP_EXP;
							end else begin
								nx.phase = jts_pkg::NP_EXPDIG;
							end
							nx.tlen = tl;
							r[0] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
						end
						c[0] = cl;
						n = 2'd1;
					end else begin
						// Any other byte closes the number and is then scanned afresh; after a lone sign or exponent mark it is an error.
						if (st.phase == jts_pkg::NP_INT || st.phase == jts_pkg::NP_FRAC ||
							st.phase == jts_pkg::NP_EXPDIG) begin
							cl = sat_add(cl, st.tlen);
							nx = jts_pkg::clear_token(st);
							r[0] = jts_pkg::mk_res((st.phase == jts_pkg::NP_INT) ?
								jts_pkg::KIND_INT : jts_pkg::KIND_FLOAT, 8'h00, 1'b0, 1'b1);
							do_idle = 1'b1;
						end else begin
							nx = jts_pkg::clear_token(st);
							nx.err = 1'b1;
							r[0] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
						end
						c[0] = cl;
						n = 2'd1;
					end
				end
				default: do_idle = 1'b1;
			endcase
		end

		if (do_idle) begin
			case (b)
				"{":     punct = jts_pkg::KIND_LBRACE;
				"}":     punct = jts_pkg::KIND_RBRACE;
				"[":     punct = jts_pkg::KIND_LBRACK;
				"]":     punct = jts_pkg::KIND_RBRACK;
				",":     punct = jts_pkg::KIND_COMMA;
				":":     punct = jts_pkg::KIND_COLON;
				default: punct = jts_pkg::KIND_NONE;
			endcase
			if (b == 8'h0A) begin
				ln = sat_add(ln, 16'd1);
				cl = POS_ONE;
			end else if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D) begin
				cl = sat_add(cl, 16'd1);
			end else begin
				if (punct != jts_pkg::KIND_NONE) begin
					cl = sat_add(cl, 16'd1);
					r[n[0]] = jts_pkg::mk_res(punct, b, 1'b1, 1'b1);
				end else if (b == "t" || b == "f" || b == "n") begin
					nx.mode = (b == "t") ? jts_pkg::MODE_KW_TRUE :
						((b == "f") ? jts_pkg::MODE_KW_FALSE : jts_pkg::MODE_KW_NULL);
					nx.kwpos = 3'd1;
					nx.tlen = 16'd1;
					r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
				end else if (b == "\"") begin
					nx.mode = jts_pkg::MODE_STRING;
					nx.tlen = 16'd1;
					nx.esc = 1'b0;
					nx.utf8 = 2'd0;
				end else if (b == "+" || b == "-" || is_digit) begin
					nx.mode = jts_pkg::MODE_NUMBER;
					nx.phase = is_digit ? jts_pkg::NP_INT : jts_pkg::NP_SIGN;
					nx.tlen = 16'd1;
					r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
				end else begin
					nx = jts_pkg::clear_token(nx);
					nx.err = 1'b1;
					r[n[0]] = jts_pkg::mk_res(jts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
				end
				if (b != "\"") begin
					c[n[0]] = cl;
					n = n + 2'd1;
				end
			end
		end
	end

	assign st_next   = nx;
	assign line_next = ln;
	assign col_next  = cl;
	assign n_res     = n;
	assign res0      = r[0];
	assign res1      = r[1];
	assign col0      = c[0];
	assign col1      = c[1];

endmodule

/* dv/json_token_scanner_top_test.sv */
// Self-checking testbench for the JSON token scanner with a scoreboard class.
module json_token_scanner_top_test;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  lexeme;
		logic        bvalid;
		logic        tend;
		logic [15:0] line;
		logic [15:0] col;
	} token_beat_t;

	class lexer_scoreboard;
		logic [2:0]  mode;
		logic [2:0]  phase;
		logic [2:0]  kwpos;
		logic [1:0]  utf8_left;
		logic        esc;
		logic        err;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] tlen;
		token_beat_t pending[$];
		int          fails;

		function void restart();
			drop_token();
			err = 1'b0;
			line = 16'd1;
			col = 16'd1;
		endfunction

		function void drop_token();
			mode = jts_pkg::MODE_IDLE;
			phase = jts_pkg::NP_SIGN;
			kwpos = 3'd0;
			utf8_left = 2'd0;
			esc = 1'b0;
			tlen = 16'd0;
		endfunction

		function logic [15:0] sat_inc(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[16] ? 16'hFFFF : s[15:0];
		endfunction

		function void emit(logic [3:0] k, logic [7:0] b, logic v, logic e);
			pending.push_back('{k, b, v, e, line, col});
		endfunction

		function void lex_error();
			drop_token();
			err = 1'b1;
			emit(jts_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1);
		endfunction

		function void close_token(logic [3:0] k, logic [7:0] b, logic v);
			col = sat_inc(col, tlen);
			drop_token();
			emit(k, b, v, 1'b1);
		endfunction

		function void grow();
			if (tlen != jts_pkg::TLEN_MAX) tlen++;
		endfunction

		function bit end_number();
			if (phase == jts_pkg::NP_INT) begin
				close_token(jts_pkg::KIND_INT, 8'd0, 1'b0);
				return 1;
			end
			if (phase == jts_pkg::NP_FRAC || phase == jts_pkg::NP_EXPDIG) begin
				close_token(jts_pkg::KIND_FLOAT, 8'd0, 1'b0);
				return 1;
			end
			lex_error();
			return 0;
		endfunction

		function void between_tokens(logic [7:0] b);
			logic [3:0] p;
			p = jts_pkg::KIND_NONE;
			if (b == 8'h0A) begin
				line = sat_inc(line, 16'd1);
				col = 16'd1;
				return;
			end
			if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
				col = sat_inc(col, 16'd1);
				return;
			end
			case (b)
				"{": p = jts_pkg::KIND_LBRACE;
				"}": p = jts_pkg::KIND_RBRACE;
				"[": p = jts_pkg::KIND_LBRACK;
				"]": p = jts_pkg::KIND_RBRACK;
				",": p = jts_pkg::KIND_COMMA;
				":": p = jts_pkg::KIND_COLON;
				default: ;
			endcase
			if (p != jts_pkg::KIND_NONE) begin
				tlen = 16'd1;
				close_token(p, b, 1'b1);
			end else if (b == "t" || b == "f" || b == "n") begin
				mode = (b == "t") ? jts_pkg::MODE_KW_TRUE :
					(b == "f") ? jts_pkg::MODE_KW_FALSE : jts_pkg::MODE_KW_NULL;
				kwpos = 3'd1;
				tlen = 16'd1;
				emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
			end else if (b == "\"") begin
				mode = jts_pkg::MODE_STRING;
				tlen = 16'd1;
			end else if (b == "+" || b == "-" || (b >= "0" && b <= "9")) begin
				mode = jts_pkg::MODE_NUMBER;
				phase = (b == "+" || b == "-") ? jts_pkg::NP_SIGN : jts_pkg::NP_INT;
				tlen = 16'd1;
				emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
			end else
				lex_error();
		endfunction

		function void in_keyword(logic [7:0] b);
			string word;
			int w;
			w = mode - jts_pkg::MODE_KW_TRUE;
			word = (w == 0) ? "true" : (w == 1) ? "false" : "null";
			if (kwpos >= word.len() || b != word[kwpos]) begin
				lex_error();
				return;
			end
			grow();
			if (kwpos + 1 == word.len())
				close_token(jts_pkg::KIND_TRUE + 4'(w), b, 1'b1);
			else begin
				kwpos++;
				emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
			end
		endfunction

		function void in_string(logic [7:0] b);
			logic [7:0] d;
			if (esc) begin
				esc = 1'b0;
				grow();
				case (b)
					"n": d = 8'h0A;
					"t": d = 8'h09;
					"\\": d = "\\";
					"\"": d = "\"";
					"r": d = 8'h0D;
					"b": d = 8'h08;
					"f": d = 8'h0C;
					default: begin
						emit(jts_pkg::KIND_NONE, "\\", 1'b1, 1'b0);
						emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
						return;
					end
				endcase
				emit(jts_pkg::KIND_NONE, d, 1'b1, 1'b0);
				return;
			end
			if (utf8_left != 0) begin
				if (b[7:6] != 2'b10) begin
					lex_error();
					return;
				end
				utf8_left--;
				grow();
				emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
				return;
			end
			grow();
			if (b == "\"") begin
				close_token(jts_pkg::KIND_STRING, 8'd0, 1'b0);
				return;
			end
			if (b == "\\") begin
				esc = 1'b1;
				return;
			end
			if (b[7])
				utf8_left = (b[7:4] == 4'hF) ? 2'd3 : (b[7:5] == 3'b111) ? 2'd2 : 2'd1;
			emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
		endfunction

		function void in_number(logic [7:0] b);
			if (b >= "0" && b <= "9") begin
				if (phase == jts_pkg::NP_SIGN) phase = jts_pkg::NP_INT;
				else if (phase == jts_pkg::NP_EXP) phase = jts_pkg::NP_EXPDIG;
			end else if (b == ".") begin
				if (phase > jts_pkg::NP_INT) begin
					lex_error();
					return;
				end
				phase = jts_pkg::NP_FRAC;
			end else if (b == "e" || b == "E") begin
				if (phase > jts_pkg::NP_FRAC || phase == jts_pkg::NP_SIGN) begin
					lex_error();
					return;
				end
				phase = jts_pkg::NP_EXP;
			end else if (b == "+" || b == "-") begin
				if (phase != jts_pkg::NP_EXP) begin
					lex_error();
					return;
				end
				phase = jts_pkg::NP_EXPDIG;
			end else begin
				if (end_number()) between_tokens(b);
				return;
			end
			grow();
			emit(jts_pkg::KIND_NONE, b, 1'b1, 1'b0);
		endfunction

		function void note_byte(logic [7:0] b, logic eoi);
			if (eoi) begin
				if (!err) begin
					if (mode == jts_pkg::MODE_NUMBER) void'(end_number());
					else if (mode != jts_pkg::MODE_IDLE) lex_error();
				end
				emit(jts_pkg::KIND_END, 8'd0, 1'b0, 1'b1);
				restart();
				return;
			end
			if (err) return;
			case (mode)
				jts_pkg::MODE_KW_TRUE, jts_pkg::MODE_KW_FALSE, jts_pkg::MODE_KW_NULL:
					in_keyword(b);
				jts_pkg::MODE_STRING: in_string(b);
				jts_pkg::MODE_NUMBER: in_number(b);
				default: between_tokens(b);
			endcase
		endfunction

		function void check_beat(token_beat_t got);
			token_beat_t exp_b;
			if (pending.size() == 0) begin
				$error("unexpected result beat kind=%0d", got.kind);
				fails++;
				return;
			end
			exp_b = pending.pop_front();
			if (got.kind != exp_b.kind) begin
				$error("token_kind exp %0d got %0d", exp_b.kind, got.kind); fails++;
			end
			if (got.lexeme != exp_b.lexeme) begin
				$error("lexeme_byte exp %0h got %0h", exp_b.lexeme, got.lexeme); fails++;
			end
			if (got.bvalid != exp_b.bvalid) begin
				$error("byte_valid exp %0d got %0d", exp_b.bvalid, got.bvalid); fails++;
			end
			if (got.tend != exp_b.tend) begin
				$error("token_end exp %0d got %0d", exp_b.tend, got.tend); fails++;
			end
			if (got.line != exp_b.line) begin
				$error("line_number exp %0d got %0d", exp_b.line, got.line); fails++;
			end
			if (got.col != exp_b.col) begin
				$error("column_number exp %0d got %0d", exp_b.col, got.col); fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        end_of_input;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  token_kind;
	logic [7:0]  lexeme_byte;
	logic        byte_valid;
	logic        token_end;
	logic [15:0] line_number;
	logic [15:0] column_number;

	lexer_scoreboard sb;
	logic [7:0] text_q[$];
	logic       eoi_q[$];

	json_token_scanner_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_byte(in_byte), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .lexeme_byte(lexeme_byte),
		.byte_valid(byte_valid), .token_end(token_end),
		.line_number(line_number), .column_number(column_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_text(string s);
		foreach (s[i]) begin
			text_q.push_back(s[i]);
			eoi_q.push_back(1'b0);
		end
	endtask

	task automatic push_end();
		text_q.push_back(8'($urandom));
		eoi_q.push_back(1'b1);
	endtask

	task automatic push_raw(logic [7:0] b);
		text_q.push_back(b);
		eoi_q.push_back(1'b0);
	endtask

	// One randomly shaped token, mostly well formed.
	task automatic push_random_token();
		int sel;
		int n;
		string punct;
		string esc_chars;
		string space_chars;
		string kw[3];
		punct = "{}[],:";
		esc_chars = "ntr\\\"bfu";
		space_chars = " \t\n\r\013\014";
		kw = '{"true", "false", "null"};
		sel = $urandom_range(0, 19);
		case (sel)
			0, 1, 2: push_raw(punct[$urandom_range(0, 5)]);
			3, 4: begin
				n = $urandom_range(0, 2);
				if ($urandom_range(0, 5) == 0)
					for (int i = 0; i < $urandom_range(1, kw[n].len()); i++)
						push_raw((i == kw[n].len() - 1) ? 8'($urandom) : kw[n][i]);
				else push_text(kw[n]);
			end
			5, 6, 7, 8: begin
				push_raw("\"");
				for (int i = 0; i < $urandom_range(0, 8); i++) begin
					n = $urandom_range(0, 9);
					if (n == 0) begin
						push_raw("\\");
						push_raw(($urandom_range(0, 1)) ? 8'($urandom) :
							esc_chars[$urandom_range(0, 7)]);
					end else if (n == 1) begin
						logic [7:0] lead;
						lead = 8'($urandom_range(128, 255));
						push_raw(lead);
						for (int k = 0;
							k < (lead[7:4] == 4'hF ? 3 : lead[7:5] == 3'b111 ? 2 : 1); k++)
							push_raw(($urandom_range(0, 9) == 0) ? 8'($urandom) :
								{2'b10, 6'($urandom)});
					end else push_raw(8'($urandom_range(32, 126)));
				end
				if ($urandom_range(0, 9) != 0) push_raw("\"");
			end
			9, 10, 11, 12, 13: begin
				string pat;
				pat = "+-0123456789.eE";
				if ($urandom_range(0, 3) == 0) push_raw(pat[$urandom_range(0, 1)]);
				for (int i = 0; i < $urandom_range(1, 4); i++)
					push_raw(8'($urandom_range("0", "9")));
				if ($urandom_range(0, 1)) begin
					push_raw(".");
					push_raw(8'($urandom_range("0", "9")));
				end
				if ($urandom_range(0, 2) == 0) begin
					push_raw($urandom_range(0, 1) ? "e" : "E");
					if ($urandom_range(0, 1)) push_raw(pat[$urandom_range(0, 1)]);
					push_raw(8'($urandom_range("0", "9")));
				end
				if ($urandom_range(0, 7) == 0) push_raw(pat[$urandom_range(0, 14)]);
			end
			14, 15: push_raw(space_chars[$urandom_range(0, 5)]);
			16: push_raw(8'($urandom));
			default: push_raw(" ");
		endcase
	endtask

	task automatic send_all();
		int gap;
		int quiet;
		quiet = 0;
		while (text_q.size() > 0) begin
			gap = (quiet > 0) ? 0 : $urandom_range(0, 18);
			if (quiet > 0) quiet--;
			else if ($urandom_range(0, 60) == 0) quiet = $urandom_range(20, 80);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= text_q.pop_front();
			end_of_input <= eoi_q.pop_front();
			do @(posedge clk); while (!in_ready);
			sb.note_byte(in_byte, end_of_input);
		end
		in_valid <= 1'b0;
	endtask

	// Receiver: for every beat, wait a random number of cycles, then take it.
	initial begin
		int wait_n;
		out_ready = 1'b0;
		forever begin
			wait_n = $urandom_range(0, 18);
			if (wait_n > 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_beat('{token_kind, lexeme_byte, byte_valid, token_end,
				line_number, column_number});
		end
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int guard;
		sb = new();
		sb.restart();
		in_valid = 1'b0;
		in_byte = 8'd0;
		end_of_input = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every token kind, escapes, UTF-8, number errors, open tokens at end.
		push_text("{}[],: true false null");
		push_end();
		push_text("\"a\\n\\q\xc3\xa9\xe2\x82\xac\xf0\x9f\x98\x80\x7f\"\n-1.5e+3 7 ");
		push_end();
		push_text("1.2.");
		push_end();
		push_text("\"\xc3A");
		push_end();
		push_text("tru");
		push_end();
		push_raw(8'hFF);
		push_raw(8'h00);
		push_end();
		push_text("-e");
		push_end();
		push_text("12");
		push_end();
		send_all();
		guard = 0;
		while (sb.pending.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end

		// Random documents, each closed by an end beat.
		for (int i = 0; text_q.size() < 1870; i++) begin
			for (int j = 0; j < $urandom_range(1, 12); j++) push_random_token();
			push_end();
			if (i % 40 == 0) push_text("\n\n \t");
		end
		send_all();
		guard = 0;
		while (sb.pending.size() > 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
